// ----- src/assert_macros.svh -----
// assertion macros for the instruction core
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define C8_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define C8_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define C8_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define C8_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/c8ic_pkg.sv -----
// constants, codes and font table of the instruction core
// no dependencies
package c8ic_pkg;

  localparam int MEM_DEPTH     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STACK_DEPTH   = 16;
  localparam int FONT_BYTES    = 80;

  localparam logic [11:0] RESET_PC = 12'h200;

  localparam logic [2:0] CMD_EXEC    = 3'd0;
  localparam logic [2:0] CMD_TICK    = 3'd1;
  localparam logic [2:0] CMD_KEY     = 3'd2;
  localparam logic [2:0] CMD_MEMWR   = 3'd3;
  localparam logic [2:0] CMD_FRAME   = 3'd4;
  localparam logic [2:0] CMD_RESTART = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_WAIT    = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEI  = 4'h3;
  localparam logic [3:0] OPC_SNEI = 4'h4;
  localparam logic [3:0] OPC_SER  = 4'h5;
  localparam logic [3:0] OPC_LDI  = 4'h6;
  localparam logic [3:0] OPC_ADDI = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDX  = 4'hA;
  localparam logic [3:0] OPC_JPV0 = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;
  localparam logic [7:0] KK_GDT  = 8'h07;
  localparam logic [7:0] KK_WKEY = 8'h0A;
  localparam logic [7:0] KK_SDT  = 8'h15;
  localparam logic [7:0] KK_SST  = 8'h18;
  localparam logic [7:0] KK_ADDI = 8'h1E;
  localparam logic [7:0] KK_FONT = 8'h29;
  localparam logic [7:0] KK_BCD  = 8'h33;
  localparam logic [7:0] KK_STR  = 8'h55;
  localparam logic [7:0] KK_LDR  = 8'h65;

  localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

endpackage

// ----- src/c8ic_in_if.sv -----
// command channel of the instruction core: valid/ready plus command payload
// no dependencies
interface c8ic_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [11:0] address;
  logic [7:0] data;
  logic [3:0] key_index;
  logic       key_down;
  logic [7:0] random_byte;

  modport source (output valid, command, address, data, key_index, key_down, random_byte,
                  input ready);
  modport sink (input valid, command, address, data, key_index, key_down, random_byte,
                output ready);
endinterface

// ----- src/c8ic_out_if.sv -----
// result channel of the instruction core: valid/ready plus result payload
// no dependencies
interface c8ic_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pc_out;
  logic [15:0] opcode_out;
  logic [2:0]  status;
  logic [63:0] frame_row;
  logic        redraw;
  logic        sound_on;

  modport source (output valid, pc_out, opcode_out, status, frame_row, redraw, sound_on,
                  input ready);
  modport sink (input valid, pc_out, opcode_out, status, frame_row, redraw, sound_on,
                output ready);
endinterface

// ----- src/c8ic_sprite_row.sv -----
// one sprite row XORed onto one screen row, with wrap and collision
// depends on c8ic_pkg
module c8ic_sprite_row (
  input  logic [7:0]  bits,
  input  logic [5:0]  col,
  input  logic [c8ic_pkg::SCREEN_WIDTH-1:0] row_in,
  output logic [c8ic_pkg::SCREEN_WIDTH-1:0] row_out,
  output logic        hit
);
  localparam int W = c8ic_pkg::SCREEN_WIDTH;

  logic [W-1:0]   base;
  logic [2*W-1:0] dbl;
  logic [W-1:0]   mask;

  assign base    = {bits, {(W-8){1'b0}}};
  assign dbl     = {base, base} >> col;
  assign mask    = dbl[W-1:0];
  assign row_out = row_in ^ mask;
  assign hit     = |(row_in & mask);
endmodule

// ----- src/chip8_instruction_core.sv -----
// channel    | dir | payload
// in_ch      | in  | command, address, data, key_index, key_down, random_byte
// out_ch     | out | pc_out, opcode_out, status, frame_row, redraw, sound_on
// cfg_we/data| in  | start_address, one write per cycle
// a command passes dispatch and done, and a frame read also reads its row; an instruction
// fetches two opcode bytes, reads Vx, Vy and V0 and executes; a flag write, Fx33, each
// sprite row and each Fx55/Fx65 register add states, and a key wait ends after the fetch
// after reset a pass loads the font and zeros the rest of memory; no transaction is taken
// the result register lets a new transaction start while the last one waits
// depends on c8ic_pkg, c8ic_in_if, c8ic_out_if, c8ic_sprite_row, assert_macros.svh
`include "assert_macros.svh"

module chip8_instruction_core (
  input  logic        clk,
  input  logic        rst_n,
  c8ic_in_if.sink     in_ch,
  c8ic_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data
);
  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_FHI  = 5'd3;
  localparam logic [4:0] S_FLO  = 5'd4;
  localparam logic [4:0] S_RVX  = 5'd5;
  localparam logic [4:0] S_RVY  = 5'd6;
  localparam logic [4:0] S_RV0  = 5'd7;
  localparam logic [4:0] S_EXEC = 5'd8;
  localparam logic [4:0] S_WRF  = 5'd9;
  localparam logic [4:0] S_DRD  = 5'd10;
  localparam logic [4:0] S_DWR  = 5'd11;
  localparam logic [4:0] S_BCD1 = 5'd12;
  localparam logic [4:0] S_BCD2 = 5'd13;
  localparam logic [4:0] S_STR  = 5'd14;
  localparam logic [4:0] S_STW  = 5'd15;
  localparam logic [4:0] S_LDR  = 5'd16;
  localparam logic [4:0] S_LDW  = 5'd17;
  localparam logic [4:0] S_FRD  = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  localparam int MD = c8ic_pkg::MEM_DEPTH;
  localparam int SH = c8ic_pkg::SCREEN_HEIGHT;
  localparam int SW = c8ic_pkg::SCREEN_WIDTH;
  localparam int SD = c8ic_pkg::STACK_DEPTH;

  // memories
  logic [7:0]    mem [0:MD-1];
  logic [7:0]    mem_q;
  logic [SW-1:0] fmem [0:SH-1];
  logic [SW-1:0] fr_q;
  logic          fr_ok_r;
  logic [7:0]    vmem [0:15];
  logic [7:0]    vr_q;
  logic          vr_ok_r;
  logic [11:0]   stk_r [0:SD-1];

  logic [4:0]  state_r;
  logic [11:0] clr_cnt_r;
  logic [11:0] start_r;
  logic [11:0] pc_r;
  logic [11:0] index_r;
  logic [4:0]  kw_r;
  logic [7:0]  delay_r;
  logic [7:0]  sound_r;
  logic [15:0] keys_r;
  logic        redraw_r;
  logic [4:0]  cnt_r;
  logic [15:0] vr_valid_r;
  logic [SH-1:0] fr_valid_r;

  logic [2:0]  cmd_r;
  logic [11:0] addr_r;
  logic [7:0]  data_r;
  logic [3:0]  key_r;
  logic        down_r;
  logic [7:0]  rnd_r;
  logic [7:0]  hi_r;
  logic [15:0] op_r;
  logic [7:0]  vx_r;
  logic [7:0]  vy_r;
  logic [7:0]  v0_r;
  logic        flag_r;
  logic        hit_r;
  logic [3:0]  r_r;
  logic [3:0]  i_r;
  logic [3:0]  tens_r;
  logic [3:0]  ones_r;
  logic [2:0]  st_r;
  logic [SW-1:0] row_r;

  logic        out_valid_r;
  logic [11:0] out_pc_r;
  logic [15:0] out_op_r;
  logic [2:0]  out_st_r;
  logic [SW-1:0] out_row_r;
  logic        out_redraw_r;
  logic        out_sound_r;

  logic        mem_we;
  logic [11:0] mem_waddr;
  logic [7:0]  mem_wdata;
  logic [11:0] mem_raddr;
  logic        vr_we;
  logic [3:0]  vr_waddr;
  logic [7:0]  vr_wdata;
  logic [3:0]  vr_raddr;
  logic        fr_we;
  logic [4:0]  fr_waddr;
  logic [SW-1:0] fr_wdata;
  logic [4:0]  fr_raddr;

  logic [7:0]  vr_val;
  logic [SW-1:0] fr_val;
  logic        in_fire;
  logic        out_free;

  logic [3:0]  op_x;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [11:0] pc_next;
  logic [11:0] pc_skip;
  logic [4:0]  cnt_m1;
  logic [4:0]  draw_row;

  logic [11:0] ex_pc;
  logic [2:0]  ex_st;
  logic        ex_vwe;
  logic [7:0]  ex_vval;
  logic        ex_flag_go;
  logic        ex_flag;

  logic [1:0]  bcd_h;
  logic [7:0]  bcd_rem8;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_tens;
  logic [6:0]  bcd_ones7;

  logic [SW-1:0] sp_row;
  logic          sp_hit;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pc_out     = out_pc_r;
  assign out_ch.opcode_out = out_op_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.frame_row  = out_row_r;
  assign out_ch.redraw     = out_redraw_r;
  assign out_ch.sound_on   = out_sound_r;

  assign vr_val = vr_ok_r ? vr_q : 8'd0;
  assign fr_val = fr_ok_r ? fr_q : '0;

  assign op_x     = op_r[11:8];
  assign kk       = op_r[7:0];
  assign nnn      = op_r[11:0];
  assign pc_next  = pc_r + 12'd2;
  assign pc_skip  = pc_r + 12'd4;
  assign cnt_m1   = cnt_r - 5'd1;
  assign draw_row = vy_r[4:0] + {1'b0, r_r};

  // decimal digits of vx
  assign bcd_h     = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
  assign bcd_rem8  = vx_r - ((vx_r >= 8'd200) ? 8'd200 : ((vx_r >= 8'd100) ? 8'd100 : 8'd0));
  assign bcd_prod  = {8'd0, bcd_rem8[6:0]} * 15'd205;
  assign bcd_tens  = bcd_prod[14:11];
  assign bcd_ones7 = bcd_rem8[6:0] - {bcd_tens, 3'b000} - {2'b00, bcd_tens, 1'b0};

  c8ic_sprite_row u_sprite (
    .bits    (mem_q),
    .col     (vx_r[5:0]),
    .row_in  (fr_val),
    .row_out (sp_row),
    .hit     (sp_hit)
  );

  // instruction decode
  always_comb begin
    ex_pc      = pc_next;
    ex_st      = c8ic_pkg::ST_OK;
    ex_vwe     = 1'b0;
    ex_vval    = 8'd0;
    ex_flag_go = 1'b0;
    ex_flag    = 1'b0;
    case (op_r[15:12])
      c8ic_pkg::OPC_SYS: begin
        if (op_r == c8ic_pkg::OP_CLS) begin
          ex_pc = pc_next;
        end else if (op_r == c8ic_pkg::OP_RET) begin
          if (cnt_r == 5'd0) begin
            ex_pc = pc_r;
            ex_st = c8ic_pkg::ST_UNDER;
          end else begin
            ex_pc = stk_r[cnt_m1[3:0]];
          end
        end else begin
          ex_st = c8ic_pkg::ST_UNKNOWN;
        end
      end
      c8ic_pkg::OPC_JP: ex_pc = nnn;
      c8ic_pkg::OPC_CALL: begin
        if (cnt_r[4]) begin
          ex_pc = pc_r;
          ex_st = c8ic_pkg::ST_OVER;
        end else begin
          ex_pc = nnn;
        end
      end
      c8ic_pkg::OPC_SEI: if (vx_r == kk) ex_pc = pc_skip;
      c8ic_pkg::OPC_SNEI: if (vx_r != kk) ex_pc = pc_skip;
      c8ic_pkg::OPC_SER: begin
        if (op_r[3:0] != 4'd0) ex_st = c8ic_pkg::ST_UNKNOWN;
        else if (vx_r == vy_r) ex_pc = pc_skip;
      end
      c8ic_pkg::OPC_SNER: begin
        if (op_r[3:0] != 4'd0) ex_st = c8ic_pkg::ST_UNKNOWN;
        else if (vx_r != vy_r) ex_pc = pc_skip;
      end
      c8ic_pkg::OPC_LDI: begin
        ex_vwe  = 1'b1;
        ex_vval = kk;
      end
      c8ic_pkg::OPC_ADDI: begin
        ex_vwe  = 1'b1;
        ex_vval = vx_r + kk;
      end
      c8ic_pkg::OPC_ALU: begin
        ex_vwe = 1'b1;
        case (op_r[3:0])
          c8ic_pkg::ALU_MOV: ex_vval = vy_r;
          c8ic_pkg::ALU_OR:  ex_vval = vx_r | vy_r;
          c8ic_pkg::ALU_AND: ex_vval = vx_r & vy_r;
          c8ic_pkg::ALU_XOR: ex_vval = vx_r ^ vy_r;
          c8ic_pkg::ALU_ADD: begin
            ex_vval    = vx_r + vy_r;
            ex_flag    = ({1'b0, vx_r} + {1'b0, vy_r}) > 9'd255;
            ex_flag_go = 1'b1;
          end
          c8ic_pkg::ALU_SUB: begin
            ex_vval    = vx_r - vy_r;
            ex_flag    = vx_r >= vy_r;
            ex_flag_go = 1'b1;
          end
          c8ic_pkg::ALU_SHR: begin
            ex_vval    = {1'b0, vx_r[7:1]};
            ex_flag    = vx_r[0];
            ex_flag_go = 1'b1;
          end
          c8ic_pkg::ALU_SBN: begin
            ex_vval    = vy_r - vx_r;
            ex_flag    = vy_r >= vx_r;
            ex_flag_go = 1'b1;
          end
          c8ic_pkg::ALU_SHL: begin
            ex_vval    = {vx_r[6:0], 1'b0};
            ex_flag    = vx_r[7];
            ex_flag_go = 1'b1;
          end
          default: begin
            ex_vwe = 1'b0;
            ex_st  = c8ic_pkg::ST_UNKNOWN;
          end
        endcase
      end
      c8ic_pkg::OPC_LDX: ex_pc = pc_next;
      c8ic_pkg::OPC_JPV0: ex_pc = {4'd0, v0_r} + nnn;
      c8ic_pkg::OPC_RND: begin
        ex_vwe  = 1'b1;
        ex_vval = rnd_r & kk;
      end
      c8ic_pkg::OPC_DRW: ex_pc = pc_next;
      c8ic_pkg::OPC_KEY: begin
        if (kk == c8ic_pkg::KK_SKP) begin
          if (keys_r[vx_r[3:0]]) ex_pc = pc_skip;
        end else if (kk == c8ic_pkg::KK_SKNP) begin
          if (!keys_r[vx_r[3:0]]) ex_pc = pc_skip;
        end else begin
          ex_st = c8ic_pkg::ST_UNKNOWN;
        end
      end
      default: begin
        case (kk)
          c8ic_pkg::KK_GDT: begin
            ex_vwe  = 1'b1;
            ex_vval = delay_r;
          end
          c8ic_pkg::KK_WKEY: begin
            ex_pc = pc_r;
            ex_st = c8ic_pkg::ST_WAIT;
          end
          c8ic_pkg::KK_SDT, c8ic_pkg::KK_SST, c8ic_pkg::KK_ADDI, c8ic_pkg::KK_FONT,
          c8ic_pkg::KK_BCD, c8ic_pkg::KK_STR, c8ic_pkg::KK_LDR: ex_pc = pc_next;
          default: ex_st = c8ic_pkg::ST_UNKNOWN;
        endcase
      end
    endcase
  end

  // memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = 12'd0;
    mem_wdata = 8'd0;
    mem_raddr = pc_r;
    vr_we     = 1'b0;
    vr_waddr  = 4'd0;
    vr_wdata  = 8'd0;
    vr_raddr  = 4'd0;
    fr_we     = 1'b0;
    fr_waddr  = draw_row;
    fr_wdata  = sp_row;
    fr_raddr  = addr_r[4:0];
    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = (clr_cnt_r < 12'(c8ic_pkg::FONT_BYTES)) ?
                    c8ic_pkg::FONT_ROM[clr_cnt_r[6:0]] : 8'd0;
      end
      S_IDLE: mem_raddr = pc_r;
      S_DISP: begin
        if (cmd_r == c8ic_pkg::CMD_MEMWR) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = data_r;
        end
        if (cmd_r == c8ic_pkg::CMD_KEY && down_r && kw_r[4]) begin
          vr_we    = 1'b1;
          vr_waddr = kw_r[3:0];
          vr_wdata = {4'd0, key_r};
        end
      end
      S_FHI: mem_raddr = pc_r + 12'd1;
      S_FLO: vr_raddr = hi_r[3:0];
      S_RVX: vr_raddr = op_r[7:4];
      S_RVY: vr_raddr = 4'd0;
      S_RV0: vr_raddr = 4'd0;
      S_EXEC: begin
        vr_we    = ex_vwe;
        vr_waddr = op_x;
        vr_wdata = ex_vval;
        if (op_r[15:12] == c8ic_pkg::OPC_MISC && kk == c8ic_pkg::KK_BCD) begin
          mem_we    = 1'b1;
          mem_waddr = index_r;
          mem_wdata = {6'd0, bcd_h};
        end
      end
      S_WRF: begin
        vr_we    = 1'b1;
        vr_waddr = 4'hF;
        vr_wdata = {7'd0, flag_r};
      end
      S_DRD: begin
        mem_raddr = index_r + {8'd0, r_r};
        fr_raddr  = draw_row;
      end
      S_DWR: fr_we = 1'b1;
      S_BCD1: begin
        mem_we    = 1'b1;
        mem_waddr = index_r + 12'd1;
        mem_wdata = {4'd0, tens_r};
      end
      S_BCD2: begin
        mem_we    = 1'b1;
        mem_waddr = index_r + 12'd2;
        mem_wdata = {4'd0, ones_r};
      end
      S_STR: vr_raddr = i_r;
      S_STW: begin
        mem_we    = 1'b1;
        mem_waddr = index_r + {8'd0, i_r};
        mem_wdata = vr_val;
      end
      S_LDR: mem_raddr = index_r + {8'd0, i_r};
      S_LDW: begin
        vr_we    = 1'b1;
        vr_waddr = i_r;
        vr_wdata = mem_q;
      end
      S_FRD: fr_raddr = addr_r[4:0];
      S_DONE: mem_raddr = pc_r;
      default: mem_raddr = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
    if (vr_we) vmem[vr_waddr] <= vr_wdata;
    vr_q    <= vmem[vr_raddr];
    vr_ok_r <= vr_valid_r[vr_raddr];
    if (fr_we) fmem[fr_waddr] <= fr_wdata;
    fr_q    <= fmem[fr_raddr];
    fr_ok_r <= fr_valid_r[fr_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= 12'd0;
      start_r      <= c8ic_pkg::RESET_PC;
      pc_r         <= c8ic_pkg::RESET_PC;
      index_r      <= 12'd0;
      kw_r         <= 5'd0;
      delay_r      <= 8'd0;
      sound_r      <= 8'd0;
      keys_r       <= 16'd0;
      redraw_r     <= 1'b0;
      cnt_r        <= 5'd0;
      vr_valid_r   <= 16'd0;
      fr_valid_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) start_r <= cfg_data;
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      if (vr_we) vr_valid_r[vr_waddr] <= 1'b1;
      if (fr_we) fr_valid_r[fr_waddr] <= 1'b1;
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 12'd1;
          if (clr_cnt_r == 12'(MD - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_r   <= in_ch.command;
            addr_r  <= in_ch.address;
            data_r  <= in_ch.data;
            key_r   <= in_ch.key_index;
            down_r  <= in_ch.key_down;
            rnd_r   <= in_ch.random_byte;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          op_r    <= 16'd0;
          row_r   <= '0;
          st_r    <= c8ic_pkg::ST_OK;
          state_r <= S_DONE;
          case (cmd_r)
            c8ic_pkg::CMD_EXEC: state_r <= S_FHI;
            c8ic_pkg::CMD_TICK: begin
              if (delay_r != 8'd0) delay_r <= delay_r - 8'd1;
              if (sound_r != 8'd0) sound_r <= sound_r - 8'd1;
            end
            c8ic_pkg::CMD_KEY: begin
              keys_r[key_r] <= down_r;
              if (down_r && kw_r[4]) begin
                kw_r <= 5'd0;
                pc_r <= pc_next;
              end
            end
            c8ic_pkg::CMD_FRAME: state_r <= S_FRD;
            c8ic_pkg::CMD_RESTART: begin
              vr_valid_r <= 16'd0;
              fr_valid_r <= '0;
              cnt_r      <= 5'd0;
              index_r    <= 12'd0;
              delay_r    <= 8'd0;
              sound_r    <= 8'd0;
              kw_r       <= 5'd0;
              redraw_r   <= 1'b0;
              pc_r       <= start_r;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_FHI: begin
          hi_r    <= mem_q;
          state_r <= S_FLO;
        end
        S_FLO: begin
          op_r <= {hi_r, mem_q};
          if (kw_r[4]) begin
            st_r    <= c8ic_pkg::ST_WAIT;
            state_r <= S_DONE;
          end else begin
            state_r <= S_RVX;
          end
        end
        S_RVX: begin
          vx_r    <= vr_val;
          state_r <= S_RVY;
        end
        S_RVY: begin
          vy_r    <= vr_val;
          state_r <= S_RV0;
        end
        S_RV0: begin
          v0_r    <= vr_val;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          pc_r    <= ex_pc;
          st_r    <= ex_st;
          state_r <= S_DONE;
          case (op_r[15:12])
            c8ic_pkg::OPC_SYS: begin
              if (op_r == c8ic_pkg::OP_CLS) begin
                fr_valid_r <= '0;
                redraw_r   <= 1'b1;
              end else if (op_r == c8ic_pkg::OP_RET && cnt_r != 5'd0) begin
                cnt_r <= cnt_m1;
              end
            end
            c8ic_pkg::OPC_CALL: begin
              if (!cnt_r[4]) begin
                stk_r[cnt_r[3:0]] <= pc_next;
                cnt_r <= cnt_r + 5'd1;
              end
            end
            c8ic_pkg::OPC_ALU: begin
              if (ex_flag_go) begin
                flag_r  <= ex_flag;
                state_r <= S_WRF;
              end
            end
            c8ic_pkg::OPC_LDX: index_r <= nnn;
            c8ic_pkg::OPC_DRW: begin
              hit_r    <= 1'b0;
              r_r      <= 4'd0;
              redraw_r <= 1'b1;
              if (op_r[3:0] == 4'd0) begin
                flag_r  <= 1'b0;
                state_r <= S_WRF;
              end else begin
                state_r <= S_DRD;
              end
            end
            c8ic_pkg::OPC_MISC: begin
              case (kk)
                c8ic_pkg::KK_WKEY: kw_r <= {1'b1, op_x};
                c8ic_pkg::KK_SDT:  delay_r <= vx_r;
                c8ic_pkg::KK_SST:  sound_r <= vx_r;
                c8ic_pkg::KK_ADDI: index_r <= index_r + {4'd0, vx_r};
                c8ic_pkg::KK_FONT: index_r <= {6'd0, vx_r[3:0], 2'b00} + {8'd0, vx_r[3:0]};
                c8ic_pkg::KK_BCD: begin
                  tens_r  <= bcd_tens;
                  ones_r  <= bcd_ones7[3:0];
                  state_r <= S_BCD1;
                end
                c8ic_pkg::KK_STR: begin
                  i_r     <= 4'd0;
                  state_r <= S_STR;
                end
                c8ic_pkg::KK_LDR: begin
                  i_r     <= 4'd0;
                  state_r <= S_LDR;
                end
                default: state_r <= S_DONE;
              endcase
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_WRF: state_r <= S_DONE;
        S_DRD: state_r <= S_DWR;
        S_DWR: begin
          hit_r <= hit_r | sp_hit;
          r_r   <= r_r + 4'd1;
          if (4'(r_r + 4'd1) == op_r[3:0]) begin
            flag_r  <= hit_r | sp_hit;
            state_r <= S_WRF;
          end else begin
            state_r <= S_DRD;
          end
        end
        S_BCD1: state_r <= S_BCD2;
        S_BCD2: state_r <= S_DONE;
        S_STR: state_r <= S_STW;
        S_STW: begin
          i_r <= i_r + 4'd1;
          state_r <= (i_r == op_x) ? S_DONE : S_STR;
        end
        S_LDR: state_r <= S_LDW;
        S_LDW: begin
          i_r <= i_r + 4'd1;
          state_r <= (i_r == op_x) ? S_DONE : S_LDR;
        end
        S_FRD: begin
          row_r   <= fr_val;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_pc_r     <= pc_r;
            out_op_r     <= op_r;
            out_st_r     <= (cmd_r == c8ic_pkg::CMD_EXEC) ? st_r :
                            (kw_r[4] ? c8ic_pkg::ST_WAIT : c8ic_pkg::ST_OK);
            out_row_r    <= row_r;
            out_redraw_r <= redraw_r;
            out_sound_r  <= (sound_r != 8'd0);
            if (cmd_r == c8ic_pkg::CMD_FRAME) redraw_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `C8_ASSERT_IMP(a_clr_no_accept, clk, rst_n, state_r == S_CLR, !in_ch.ready, "transaction taken during memory load")
  `C8_ASSERT_IMP(a_stack_bound, clk, rst_n, 1'b1, cnt_r <= 5'(SD), "return stack count beyond depth")
  `C8_ASSERT_NXT(a_call_full, clk, rst_n, state_r == S_EXEC && op_r[15:12] == c8ic_pkg::OPC_CALL && cnt_r[4], cnt_r == $past(cnt_r) && pc_r == $past(pc_r), "call on full stack changed state")
  `C8_ASSERT_NXT(a_done_load, clk, rst_n, state_r == S_DONE && out_free, out_valid_r && state_r == S_IDLE, "result not loaded on completion")

endmodule
